// ----- hdl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Opcodes, slot marks, table geometry and the slot record layout.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry; slot count must be a power of two (home slot is a mask)
  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
  localparam int unsigned PAYLOAD_W   = 64;

  localparam logic [63:0] PAYLOAD_MASK =
    (PAYLOAD_W >= 64) ? {64{1'b1}} : ((64'd1 << (PAYLOAD_W % 64)) - 64'd1);

  // Multiplicative hash
  localparam logic [31:0] HASH_MUL  = 32'h9E37_79B1;
  localparam int unsigned HASH_FOLD = 16;

  // Opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  mark;
    logic [30:0] owner;
    logic [30:0] fd;
    logic [63:0] payload;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// ----- hdl/linear_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// Lookup, store and clear of a payload keyed by (owner id, descriptor), with
// tombstones, on a single slot RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                       Handshake
// --------  ------------------------------------------  ----------------------
// command   opcode, owner_id, key_fd, entry_value       start & !busy
// result    found, read_value, status                   done (one-cycle strobe)
//
// Sequence: a command with a zero owner or an unused opcode answers in the
// next cycle. Otherwise two multiplies on one shared 32x32 multiplier and a
// fold (S_MUL_O, S_MUL_K, S_FOLD) run first, then each probe is a RAM read
// and a compare (S_RD, S_CHK), 1..TABLE_SLOTS probes; no new command is taken
// until the result. Reset: a clearing pass writes every slot empty, one per
// cycle, with busy high. The result beat cannot be stalled.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [30:0] owner_id,
  input  logic [30:0] key_fd,
  input  logic [63:0] entry_value,
  output logic        done,
  output logic        found,
  output logic [63:0] read_value,
  output logic        status
);

  // Sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL_O = 3'd2;
  localparam logic [2:0] S_MUL_K = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CHK   = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] clr_addr, clr_addr_next;

  // Latched command
  logic [1:0]  op, op_next;
  logic [30:0] owner, owner_next;
  logic [30:0] fd, fd_next;
  logic [63:0] val, val_next;

  // Hash and probe walk
  logic [31:0]      h, h_next;
  logic [31:0]      h_fold;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] spare, spare_next;
  logic             spare_ok, spare_ok_next;

  // Result beat
  logic        done_next;
  logic        found_next;
  logic [63:0] read_value_next;
  logic        status_next;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_prod;

  // Slot RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic             ram_re;
  slot_t            ram_rdata;

  // Probe decode
  logic slot_match;
  logic slot_empty;
  logic slot_free;
  logic walk_end;

  lpht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // One multiplier serves both key halves; only the low 32 bits matter
  assign mul_a    = (state == S_MUL_O) ? {1'b0, owner} : {1'b0, fd};
  assign mul_prod = mul_a * HASH_MUL;

  assign h_fold = h ^ (h >> HASH_FOLD);

  assign slot_match = (ram_rdata.mark == MARK_USED) && (ram_rdata.owner == owner) &&
                      (ram_rdata.fd == fd);
  assign slot_empty = (ram_rdata.mark == MARK_EMPTY);
  assign slot_free  = slot_empty || (ram_rdata.mark == MARK_TOMB);
  assign walk_end   = slot_empty || (cnt == LAST_IDX);

  assign ram_re = (state == S_RD);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    op_next         = op;
    owner_next      = owner;
    fd_next         = fd;
    val_next        = val;
    h_next          = h;
    idx_next        = idx;
    cnt_next        = cnt;
    spare_next      = spare;
    spare_ok_next   = spare_ok;
    done_next       = 1'b0;
    found_next      = found;
    read_value_next = read_value;
    status_next     = status;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = '0;

    unique case (state)
      S_CLEAR: begin
        // Sweep the table to empty, one slot a cycle
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_next    = opcode;
          owner_next = owner_id;
          fd_next    = key_fd;
          val_next   = entry_value & PAYLOAD_MASK;
          if ((owner_id == 31'd0) || !((opcode == OP_LOOKUP) || (opcode == OP_STORE) ||
                                      (opcode == OP_CLEAR))) begin
            // Reserved owner or unused opcode: answer at once, touch nothing
            done_next       = 1'b1;
            found_next      = 1'b0;
            read_value_next = '0;
            status_next     = (opcode == OP_STORE);
          end else begin
            state_next = S_MUL_O;
          end
        end
      end
      S_MUL_O: begin
        h_next     = mul_prod;
        state_next = S_MUL_K;
      end
      S_MUL_K: begin
        h_next     = h ^ mul_prod;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        idx_next      = h_fold[IDX_W-1:0];
        cnt_next      = '0;
        spare_ok_next = 1'b0;
        state_next    = S_RD;
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (slot_match) begin
          // Hit: act on this slot and finish
          done_next       = 1'b1;
          found_next      = 1'b1;
          read_value_next = (op == OP_LOOKUP) ? (ram_rdata.payload & PAYLOAD_MASK) : '0;
          status_next     = 1'b0;
          ram_waddr       = idx;
          if (op == OP_STORE) begin
            ram_we            = 1'b1;
            ram_wdata.mark    = MARK_USED;
            ram_wdata.owner   = owner;
            ram_wdata.fd      = fd;
            ram_wdata.payload = val;
          end else if (op == OP_CLEAR) begin
            ram_we         = 1'b1;
            ram_wdata.mark = MARK_TOMB;
          end
          state_next = S_IDLE;
        end else if (walk_end) begin
          // Miss: a store claims the first free slot seen
          done_next       = 1'b1;
          found_next      = 1'b0;
          read_value_next = '0;
          status_next     = 1'b0;
          if (op == OP_STORE) begin
            if (spare_ok || slot_free) begin
              ram_we            = 1'b1;
              ram_waddr         = spare_ok ? spare : idx;
              ram_wdata.mark    = MARK_USED;
              ram_wdata.owner   = owner;
              ram_wdata.fd      = fd;
              ram_wdata.payload = val;
            end else begin
              status_next = 1'b1;
            end
          end
          state_next = S_IDLE;
        end else begin
          // Remember the first tombstone, advance with wrap
          if (slot_free && !spare_ok) begin
            spare_next    = idx;
            spare_ok_next = 1'b1;
          end
          idx_next   = idx + 1'b1;
          cnt_next   = cnt + 1'b1;
          state_next = S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    owner      <= owner_next;
    fd         <= fd_next;
    val        <= val_next;
    h          <= h_next;
    idx        <= idx_next;
    cnt        <= cnt_next;
    spare      <= spare_next;
    spare_ok   <= spare_ok_next;
    found      <= found_next;
    read_value <= read_value_next;
    status     <= status_next;
  end

`ifndef SYNTHESIS
  // Result beat only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while sequencer busy");

  // Payload only comes back from a hit
  a_value_hit: assert property (@(posedge clk) disable iff (rst)
    (done && (read_value != 64'd0)) |-> found)
    else $error("nonzero read value without a hit");

  // Table full and hit never reported together
  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !found)
    else $error("status set on a hit");

  // Clearing pass holds busy right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> busy)
    else $error("accepting commands during clearing pass");

  // RAM is only written by the sweep or the compare step
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_CHK)))
    else $error("slot write outside sweep or compare");
`endif

endmodule

// ----- hdl/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
